// ===== rtl/numeric_text_to_integer_parser_core_assert.svh =====
// Assertion helpers for the parser back end (ntip_back).
`ifndef NUMERIC_TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH
`define NUMERIC_TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NTIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NTIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define NTIP_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ntip_pkg.sv =====
package ntip_pkg;

  // Number format codes
  localparam logic [1:0] FMT_HEX  = 2'd0;
  localparam logic [1:0] FMT_SDEC = 2'd1;
  localparam logic [1:0] FMT_UDEC = 2'd2;

  // Character codes
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LF    = 16'h0066;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UF    = 16'h0046;
  localparam logic [15:0] CH_LX    = 16'h0078;
  localparam logic [15:0] CH_UX    = 16'h0058;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int VAL_W = 64;

  typedef enum logic [2:0] {
    PH_LEAD     = 3'd0,
    PH_SIGNED   = 3'd1,
    PH_HEXZERO  = 3'd2,
    PH_PREFIXED = 3'd3,
    PH_DIGITS   = 3'd4,
    PH_TRAIL    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic        char_present;
    logic        end_of_text;
  } in_req_t;

  typedef struct packed {
    logic             parse_ok;
    logic [VAL_W-1:0] result_value;
  } out_req_t;

  // Classified character as it travels through the queue
  typedef struct packed {
    logic       present;
    logic       last;
    logic [1:0] mode;
    logic       is_space;
    logic       is_zero;
    logic       is_x;
    logic       is_plus;
    logic       is_minus;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
  } token_t;

  // Datapath actions chosen by the phase logic
  typedef struct packed {
    logic load_zero;
    logic set_sign;
    logic take_digit;
  } action_t;

endpackage

// ===== rtl/ntip_front.sv =====
module ntip_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  ntip_pkg::in_req_t in_req,
  input  logic              q_full,
  output logic              q_push,
  output ntip_pkg::token_t  q_tok
);

  logic [1:0]  number_format;
  logic [15:0] c;

  // Hold the format register
  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= ntip_pkg::FMT_HEX;
    end else if (cfg_we) begin
      number_format <= cfg_wdata;
    end
  end

  // Accept a request whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign c        = in_req.char_code;

  // Classify the character under the current format
  always_comb begin
    q_tok          = '0;
    q_tok.present  = in_req.char_present;
    q_tok.last     = in_req.end_of_text;
    q_tok.mode     = number_format;
    q_tok.is_space = (c == ntip_pkg::CH_SPACE) ||
                     (c inside {[ntip_pkg::CH_TAB:ntip_pkg::CH_CR]});
    q_tok.is_zero  = (c == ntip_pkg::CH_ZERO);
    q_tok.is_x     = (c == ntip_pkg::CH_LX) || (c == ntip_pkg::CH_UX);
    q_tok.is_plus  = (c == ntip_pkg::CH_PLUS);
    q_tok.is_minus = (c == ntip_pkg::CH_MINUS);
    q_tok.dec_ok   = c inside {[ntip_pkg::CH_ZERO:ntip_pkg::CH_NINE]};
    q_tok.hex_ok   = q_tok.dec_ok ||
                     (c inside {[ntip_pkg::CH_LA:ntip_pkg::CH_LF]}) ||
                     (c inside {[ntip_pkg::CH_UA:ntip_pkg::CH_UF]});
    q_tok.digit    = q_tok.dec_ok ? c[3:0] : c[3:0] + 4'd9;
  end

endmodule

// ===== rtl/ntip_queue.sv =====
module ntip_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ntip_pkg::token_t wr_tok,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output ntip_pkg::token_t rd_tok
);

  ntip_pkg::token_t       entries [ntip_pkg::QDEPTH];
  logic [ntip_pkg::QAW-1:0] wr_ptr;
  logic [ntip_pkg::QAW-1:0] rd_ptr;
  logic [ntip_pkg::QAW:0]   count;

  assign full   = (count == (ntip_pkg::QAW+1)'(ntip_pkg::QDEPTH));
  assign valid  = (count != '0);
  assign rd_tok = entries[rd_ptr];

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_tok;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ntip_back.sv =====
`include "numeric_text_to_integer_parser_core_assert.svh"

module ntip_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ntip_pkg::token_t   tok,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ntip_pkg::out_req_t out_rsp
);

  ntip_pkg::phase_t             phase;
  ntip_pkg::phase_t             phase_next;
  logic [ntip_pkg::VAL_W-1:0]   acc;
  logic [ntip_pkg::VAL_W-1:0]   acc_next;
  logic                         neg;
  logic                         neg_next;
  logic                         failed;
  logic                         failed_next;
  ntip_pkg::action_t            act;
  logic                         digit_ok;
  logic                         finish;
  logic                         fin_ok;
  logic                         out_ok;
  logic                         out_neg;
  logic [ntip_pkg::VAL_W-1:0]   out_mag;
  logic                         live;

  // Take a token unless it ends a string and the result slot is blocked
  assign q_pop  = q_valid && (!tok.last || !out_valid || out_ready);
  assign finish = q_pop && tok.last;
  assign live   = q_pop && tok.present && !failed;

  // Check whether the token is a digit of its format; in hex, also that the accumulator has room for it
  always_comb begin
    case (tok.mode)
      ntip_pkg::FMT_HEX:  digit_ok = tok.hex_ok && (acc[63:60] == 4'd0);
      ntip_pkg::FMT_SDEC: digit_ok = tok.dec_ok;
      ntip_pkg::FMT_UDEC: digit_ok = tok.dec_ok;
      default:            digit_ok = 1'b0;
    endcase
  end

  // Next phase, failure and datapath action
  always_comb begin
    logic try_digit;
    try_digit   = 1'b0;
    phase_next  = phase;
    failed_next = failed;
    act         = '0;
    if (live) begin
      case (phase)
        ntip_pkg::PH_LEAD: begin
          if (tok.is_space) begin
            phase_next = phase;
          end else if (tok.mode == ntip_pkg::FMT_HEX && tok.is_zero) begin
            act.load_zero = 1'b1;
            phase_next    = ntip_pkg::PH_HEXZERO;
          end else if (tok.mode == ntip_pkg::FMT_SDEC && (tok.is_plus || tok.is_minus)) begin
            act.set_sign = 1'b1;
            phase_next   = ntip_pkg::PH_SIGNED;
          end else begin
            try_digit = 1'b1;
          end
        end
        ntip_pkg::PH_SIGNED, ntip_pkg::PH_PREFIXED: begin
          if (tok.is_space) begin
            failed_next = 1'b1;
          end else begin
            try_digit = 1'b1;
          end
        end
        ntip_pkg::PH_HEXZERO: begin
          if (tok.mode == ntip_pkg::FMT_HEX && tok.is_x) begin
            phase_next = ntip_pkg::PH_PREFIXED;
          end else if (tok.is_space) begin
            phase_next = ntip_pkg::PH_TRAIL;
          end else begin
            try_digit = 1'b1;
          end
        end
        ntip_pkg::PH_DIGITS: begin
          if (tok.is_space) begin
            phase_next = ntip_pkg::PH_TRAIL;
          end else begin
            try_digit = 1'b1;
          end
        end
        ntip_pkg::PH_TRAIL: begin
          if (!tok.is_space) begin
            failed_next = 1'b1;
          end
        end
        default: failed_next = 1'b1;
      endcase
      if (try_digit) begin
        if (digit_ok) begin
          act.take_digit = 1'b1;
          phase_next     = ntip_pkg::PH_DIGITS;
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  // Accumulate: load zero, latch the sign, and shift in a hex digit or multiply by ten and add
  always_comb begin
    acc_next = acc;
    neg_next = neg;
    if (act.load_zero) begin
      acc_next = '0;
    end
    if (act.set_sign) begin
      neg_next = tok.is_minus;
    end
    if (act.take_digit) begin
      if (tok.mode == ntip_pkg::FMT_HEX) begin
        acc_next = {acc[59:0], tok.digit};
      end else begin
        acc_next = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} +
                   {{(ntip_pkg::VAL_W-4){1'b0}}, tok.digit};
      end
    end
  end

  assign fin_ok = !failed_next && (phase_next == ntip_pkg::PH_DIGITS ||
                                   phase_next == ntip_pkg::PH_TRAIL ||
                                   phase_next == ntip_pkg::PH_HEXZERO);

  // Advance string state; drop it back to the start after the last token
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      phase  <= ntip_pkg::PH_LEAD;
      acc    <= '0;
      neg    <= 1'b0;
      failed <= 1'b0;
    end else begin
      phase  <= phase_next;
      acc    <= acc_next;
      neg    <= neg_next;
      failed <= failed_next;
    end
  end

  // Hold the finished result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ok  <= fin_ok;
      out_neg <= neg_next;
      out_mag <= fin_ok ? acc_next : '0;
    end
  end

  // Negate on the way out in signed mode
  assign out_rsp.parse_ok     = out_ok;
  assign out_rsp.result_value = out_neg ? ('0 - out_mag) : out_mag;

  `NTIP_ASSERT_ALWAYS(a_reset_phase, rst, phase == ntip_pkg::PH_LEAD && !failed, "reset left string state")
  `NTIP_ASSERT_NEXT(a_finish_clears, finish, phase == ntip_pkg::PH_LEAD && !failed && !neg && acc == '0, "string state not cleared")
  `NTIP_ASSERT_NOW(a_no_overwrite, finish, !out_valid || out_ready, "result overwritten")
  `NTIP_ASSERT_NOW(a_rise_from_finish, $rose(out_valid), $past(finish), "result without end of string")
  `NTIP_ASSERT_NEXT(a_fail_sticks, failed && !finish, failed, "failure cleared mid-string")

endmodule

// ===== rtl/numeric_text_to_integer_parser_core.sv =====
// Streaming text-to-integer parser.
// Input channel in_valid/in_ready/in_req carries one UTF-16 character per
// request; end_of_text marks the last one, char_present 0 is an empty marker.
// Output channel out_valid/out_ready/out_rsp carries one result per string:
// parse_ok and a 64-bit value (two's complement in signed mode, 0 on failure).
// cfg_we/cfg_wdata writes number_format: 0 hex, 1 signed decimal,
// 2 unsigned decimal. Write it only while no string is in flight.
// Throughput: one character per cycle while in_ready is high. Each character
// costs one multiply-by-ten (or shift-by-four) and add on the 64-bit
// accumulator in the back end. The back end pops the last character from the
// four-entry queue and registers the result, raising out_valid; the receiver
// can take it at once. If the receiver stalls, the result waits in the output
// register; the back end keeps parsing the next string up to its last
// character, then the queue fills to four entries and in_ready drops.
// Reset (rst, synchronous) empties the queue, drops any result, clears the
// string state and sets the format to hexadecimal.
module numeric_text_to_integer_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  ntip_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output ntip_pkg::out_req_t out_rsp
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  ntip_pkg::token_t wr_tok;
  ntip_pkg::token_t rd_tok;

  ntip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (wr_tok)
  );

  ntip_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_tok (wr_tok),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_tok (rd_tok)
  );

  ntip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .tok       (rd_tok),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule
